// ===== src/gateway_seed_key_responder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Gateway seed/key responder: assertion macros
// Shared assertion forms for the responder modules.
// ----------------------------------------------------------------------------
`ifndef GATEWAY_SEED_KEY_RESPONDER_UNIT_DEFINES_SVH
`define GATEWAY_SEED_KEY_RESPONDER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gsk_pkg.sv =====
// ----------------------------------------------------------------------------
// Gateway seed/key responder package
// Service codes, request templates, key constants and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package gsk_pkg;

    localparam logic [7:0] SvcSession  = 8'h10;
    localparam logic [7:0] SvcSecurity = 8'h27;
    localparam logic [7:0] SvcRoutine  = 8'h31;

    localparam logic [7:0] SubSessDefault = 8'h01;
    localparam logic [7:0] SubSessExt     = 8'h03;
    localparam logic [7:0] SubSeedOne     = 8'h41;
    localparam logic [7:0] SubKeyOne      = 8'h42;
    localparam logic [7:0] SubSeedTwo     = 8'h01;
    localparam logic [7:0] SubKeyTwo      = 8'h02;
    localparam logic [7:0] SubRtnStart    = 8'h01;
    localparam logic [7:0] SubRtnDone     = 8'h03;

    localparam logic [7:0] PciLen2 = 8'h02;
    localparam logic [7:0] PciLen4 = 8'h04;
    localparam logic [7:0] PciLen5 = 8'h05;
    localparam logic [7:0] PciLen6 = 8'h06;

    localparam logic [31:0] SeedReqPayload = 32'h3eab000d;
    localparam logic [31:0] RoutinePayload = 32'haaff0000;

    localparam int unsigned ExpBits   = 13;
    localparam logic [ExpBits-1:0] KeyExp = 13'h12e5;
    localparam logic [3:0]  ExpTop    = 4'(ExpBits - 1);
    localparam logic [31:0] BarrettMul = 32'h82b87f05;
    localparam logic [15:0] BarrettLo  = BarrettMul[15:0];
    localparam logic [15:0] BarrettHi  = BarrettMul[31:16];
    localparam logic [31:0] Modulus    = 32'h00003eab;
    localparam logic [31:0] MixXor     = 32'h0000000f;
    localparam logic [31:0] KeyOneXor  = 32'had0779e2;
    localparam logic [6:0]  ShiftBase  = 7'h25;
    localparam logic [4:0]  ShiftFlip  = 5'h08;
    localparam logic [31:0] KeyTwoXor  = 32'hdc8fe1ae;

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_KEY1,
        KIND_KEY2
    } kind_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_HI,
        OP_RED,
        OP_LFSR
    } op_t;

    typedef struct packed {
        kind_t       kind;
        logic        send;
        logic        done_res;
        logic [7:0]  pci_byte;
        logic [7:0]  request_service;
        logic [7:0]  request_sub;
        logic [31:0] payload;
    } dec_t;

    // High part of the product with the Barrett factor, built from truncated
    // 16-bit partial products.
    function automatic logic [18:0] mul_hi45(input logic [31:0] a);
        logic [31:0] pll;
        logic [31:0] plh;
        logic [31:0] phl;
        logic [31:0] phh;
        logic [31:0] t1;
        logic [31:0] t2;
        pll = 32'(a[15:0]) * 32'(BarrettLo);
        plh = 32'(a[15:0]) * 32'(BarrettHi);
        phl = 32'(BarrettLo) * 32'(a[31:16]);
        phh = 32'(a[31:16]) * 32'(BarrettHi);
        t1  = {16'd0, pll[31:16]} + plh + phl;
        t2  = {16'd0, t1[31:16]} + phh;
        return t2[31:13];
    endfunction

    function automatic logic [31:0] key_one_mix(input logic [31:0] acc);
        logic [31:0] m;
        logic [31:0] hi;
        logic [31:0] lo;
        m  = ((acc >> 8) + acc) ^ MixXor;
        hi = (acc ^ (m << 8)) & 32'h0000ff00;
        lo = ((acc ^ m) & 32'h000000ff) | hi;
        return {lo[15:0], lo[15:0]} ^ KeyOneXor;
    endfunction

endpackage

`default_nettype wire

// ===== src/gsk_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Carries one received diagnostic response word with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsk_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  service_id;
    logic [7:0]  response_sub;
    logic [31:0] seed;

    modport source (output valid, output service_id, output response_sub, output seed,
                    input ready);
    modport sink   (input valid, input service_id, input response_sub, input seed,
                    output ready);
endinterface

`default_nettype wire

// ===== src/gsk_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Carries one request frame word with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsk_req_if;
    logic        valid;
    logic        ready;
    logic        send;
    logic        done_res;
    logic [7:0]  pci_byte;
    logic [7:0]  request_service;
    logic [7:0]  request_sub;
    logic [31:0] payload;

    modport source (output valid, output send, output done_res, output pci_byte,
                    output request_service, output request_sub, output payload,
                    input ready);
    modport sink   (input valid, input send, input done_res, input pci_byte,
                    input request_service, input request_sub, input payload,
                    output ready);
endinterface

`default_nettype wire

// ===== src/gsk_decode.sv =====
// ----------------------------------------------------------------------------
// Response decoder
// Maps a response service and subfunction to the request template and the
// kind of key work that it needs.
// ----------------------------------------------------------------------------
`default_nettype none

module gsk_decode (
    input  wire logic [7:0] service_id,
    input  wire logic [7:0] response_sub,
    output gsk_pkg::dec_t   dec
);
    import gsk_pkg::*;

    always_comb
    begin
        dec = '{kind: KIND_PLAIN, send: 1'b1, done_res: 1'b0, pci_byte: 8'd0,
                request_service: 8'd0, request_sub: 8'd0, payload: 32'd0};
        unique case ({service_id, response_sub})
            {SvcSession, SubSessDefault}:
            begin
                dec.pci_byte        = PciLen2;
                dec.request_service = SvcSession;
                dec.request_sub     = SubSessExt;
            end
            {SvcSession, SubSessExt}:
            begin
                dec.pci_byte        = PciLen6;
                dec.request_service = SvcSecurity;
                dec.request_sub     = SubSeedOne;
                dec.payload         = SeedReqPayload;
            end
            {SvcSecurity, SubSeedOne}:
            begin
                dec.kind            = KIND_KEY1;
                dec.pci_byte        = PciLen6;
                dec.request_service = SvcSecurity;
                dec.request_sub     = SubKeyOne;
            end
            {SvcSecurity, SubKeyOne}:
            begin
                dec.pci_byte        = PciLen2;
                dec.request_service = SvcSecurity;
                dec.request_sub     = SubSeedTwo;
            end
            {SvcSecurity, SubSeedTwo}:
            begin
                dec.kind            = KIND_KEY2;
                dec.pci_byte        = PciLen6;
                dec.request_service = SvcSecurity;
                dec.request_sub     = SubKeyTwo;
            end
            {SvcSecurity, SubKeyTwo}:
            begin
                dec.pci_byte        = PciLen5;
                dec.request_service = SvcRoutine;
                dec.request_sub     = SubRtnStart;
                dec.payload         = RoutinePayload;
            end
            {SvcRoutine, SubRtnStart}:
            begin
                dec.pci_byte        = PciLen4;
                dec.request_service = SvcRoutine;
                dec.request_sub     = SubRtnDone;
                dec.payload         = RoutinePayload;
            end
            {SvcRoutine, SubRtnDone}:
            begin
                dec.send     = 1'b0;
                dec.done_res = 1'b1;
            end
            default:
            begin
                dec.send = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/gsk_arith.sv =====
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// One 32-bit wrapping multiplier with the Barrett quotient estimate, the
// reduction subtract and the shift feedback step, selected by operation.
// ----------------------------------------------------------------------------
`default_nettype none

module gsk_arith (
    input  gsk_pkg::op_t      op,
    input  wire logic [31:0]  a,
    input  wire logic [31:0]  b,
    output logic [31:0]       r
);
    import gsk_pkg::*;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] prod;
    logic [31:0] fbw;

    always_comb
    begin
        mul_a = a;
        mul_b = b;
        if (op == OP_RED)
        begin
            mul_a = b;
            mul_b = Modulus;
        end
    end

    assign prod = mul_a * mul_b;
    assign fbw  = ((((((a >> 6) ^ a) >> 12) ^ a) >> 10) ^ a) >> 2;

    always_comb
    begin
        unique case (op)
            OP_MUL:  r = prod;
            OP_HI:   r = {13'd0, mul_hi45(a)};
            OP_RED:  r = a - prod;
            OP_LFSR: r = {a[30:0], fbw[0]};
        endcase
    end

endmodule

`default_nettype wire

// ===== src/gateway_seed_key_responder_unit.sv =====
// ----------------------------------------------------------------------------
// Gateway seed/key responder
// Answers each diagnostic response word with the next request frame word.
// ----------------------------------------------------------------------------
// The rsp channel takes one response word (service, subfunction, seed) when
// valid and ready are both high; ready is high only while the sequencer idles.
// The req channel gives exactly one request word per response, held in an
// output register until it is taken.
// Plain responses go from acceptance through S_LOAD to the output register.
// Key 1 runs square-and-multiply over the 13 exponent bits: 19 modular
// products (12 squarings and 7 multiplies, with no squaring after the top
// bit), each through S_MUL, S_HI and S_RED of the shared multiplier (product,
// quotient estimate, subtract).
// Key 2 runs the shift feedback register one step per cycle, 37 to 65 steps
// set by seed bits 28 to 26.
// The next response is taken in the cycle after a result reaches the output
// register.
// A new response is accepted while the previous request word still waits.
// If the receiver stalls, a finished result waits in the sequencer until the
// output register is free, and no further response is accepted meanwhile.
// Reset clears the sequencer and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gateway_seed_key_responder_unit_defines.svh"

module gateway_seed_key_responder_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    gsk_rsp_if.sink   rsp,
    gsk_req_if.source req
);
    import gsk_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_HI    = 6'b000100,
        S_RED   = 6'b001000,
        S_SHIFT = 6'b010000,
        S_LOAD  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    dec_t        dec_reg, dec_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] p_reg, p_next;
    logic [18:0] q_reg, q_next;
    logic [3:0]  ebit_reg, ebit_next;
    logic        tgt_base_reg, tgt_base_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic        send_reg, done_res_reg;
    logic [7:0]  pci_reg, rsvc_reg, rsub_reg;
    logic [31:0] payload_reg, payload_next;

    dec_t        dec;
    op_t         op;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] res;
    logic [3:0]  ebit_inc;
    logic        load;

    gsk_decode u_decode (
        .service_id   (rsp.service_id),
        .response_sub (rsp.response_sub),
        .dec          (dec)
    );

    gsk_arith u_arith (
        .op (op),
        .a  (op_a),
        .b  (op_b),
        .r  (res)
    );

    assign rsp.ready = (state_reg == S_IDLE);
    assign ebit_inc  = ebit_reg + 4'd1;
    assign load      = (state_reg == S_LOAD) && (!out_valid_reg || req.ready);

    always_comb
    begin
        op   = OP_MUL;
        op_a = p_reg;
        op_b = {13'd0, q_reg};
        unique case (state_reg)
            S_MUL:
            begin
                op   = OP_MUL;
                op_a = tgt_base_reg ? base_reg : acc_reg;
                op_b = base_reg;
            end
            S_HI:    op = OP_HI;
            S_RED:   op = OP_RED;
            S_SHIFT:
            begin
                op   = OP_LFSR;
                op_a = acc_reg;
            end
            default: op = OP_MUL;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        dec_next      = dec_reg;
        acc_next      = acc_reg;
        base_next     = base_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        ebit_next     = ebit_reg;
        tgt_base_next = tgt_base_reg;
        cnt_next      = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (rsp.valid)
                begin
                    dec_next      = dec;
                    base_next     = {16'd0, rsp.seed[15:0]};
                    ebit_next     = 4'd0;
                    tgt_base_next = !KeyExp[0];
                    cnt_next      = ShiftBase
                                  + 7'({rsp.seed[28:26], 2'b00} ^ ShiftFlip);
                    unique case (dec.kind)
                        KIND_KEY1:
                        begin
                            acc_next   = 32'd1;
                            state_next = S_MUL;
                        end
                        KIND_KEY2:
                        begin
                            acc_next   = rsp.seed;
                            state_next = S_SHIFT;
                        end
                        default: state_next = S_LOAD;
                    endcase
                end
            end
            S_MUL:
            begin
                p_next     = res;
                state_next = S_HI;
            end
            S_HI:
            begin
                q_next     = res[18:0];
                state_next = S_RED;
            end
            S_RED:
            begin
                if (tgt_base_reg)
                begin
                    base_next     = res;
                    ebit_next     = ebit_inc;
                    tgt_base_next = !KeyExp[ebit_inc];
                    state_next    = S_MUL;
                end
                else
                begin
                    acc_next = res;
                    if (ebit_reg == ExpTop)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        tgt_base_next = 1'b1;
                        state_next    = S_MUL;
                    end
                end
            end
            S_SHIFT:
            begin
                acc_next = res;
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (dec_reg.kind)
            KIND_KEY1: payload_next = key_one_mix(acc_reg);
            KIND_KEY2: payload_next = acc_reg ^ KeyTwoXor;
            default:   payload_next = dec_reg.payload;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (req.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg      <= dec_next;
        acc_reg      <= acc_next;
        base_reg     <= base_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        ebit_reg     <= ebit_next;
        tgt_base_reg <= tgt_base_next;
        cnt_reg      <= cnt_next;
        if (load)
        begin
            send_reg     <= dec_reg.send;
            done_res_reg <= dec_reg.done_res;
            pci_reg      <= dec_reg.pci_byte;
            rsvc_reg     <= dec_reg.request_service;
            rsub_reg     <= dec_reg.request_sub;
            payload_reg  <= payload_next;
        end
    end

    assign req.valid           = out_valid_reg;
    assign req.send            = send_reg;
    assign req.done_res        = done_res_reg;
    assign req.pci_byte        = pci_reg;
    assign req.request_service = rsvc_reg;
    assign req.request_sub     = rsub_reg;
    assign req.payload         = payload_reg;

    `GSK_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, rsp.valid && rsp.ready, state_reg != S_IDLE, "accepted word did not start work")
    `GSK_ASSERT_SAME(a_exp_bit_range, clk, rst_n, state_reg == S_MUL, ebit_reg <= ExpTop, "exponent bit index out of range")
    `GSK_ASSERT_SAME(a_send_done_excl, clk, rst_n, out_valid_reg, !(send_reg && done_res_reg), "send and done both set")
    `GSK_ASSERT_NEXT(a_load_waits, clk, rst_n, state_reg == S_LOAD && out_valid_reg && !req.ready, state_reg == S_LOAD, "result dropped while output stalled")

endmodule

`default_nettype wire
